>>> design/sem_pkg.sv
// Shared types and constants for the Sobel edge magnitude block.
package sem_pkg;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_SHIFT,
    ST_GRAD,
    ST_SQR,
    ST_MUL,
    ST_SEED,
    ST_ROOT,
    ST_LOAD
  } state_e;

  // Result kinds of one input pixel, in emission order
  typedef enum logic [1:0] {
    KIND_DIAG   = 2'd0,  // (r-1, c-1)
    KIND_RIGHT  = 2'd1,  // (r-1, c) at the last column
    KIND_BOTTOM = 2'd2,  // (r, c-1) on the last row
    KIND_CORNER = 2'd3   // (r, c) last pixel of the frame
  } kind_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_SENS   = 2'd2;

  // Gray conversion weights, 16 fraction bits
  localparam logic [15:0] COEF_R = 16'd19595;
  localparam logic [15:0] COEF_G = 16'd38470;
  localparam logic [15:0] COEF_B = 16'd7471;

  // Root unit sizing: radicand below 2^42, first trial bit at 2^40
  localparam int unsigned RAD_W = 42;

  // Commands from controller to datapath
  typedef struct packed {
    logic  accept;
    logic  gray;
    logic  shift;
    logic  grad;
    logic  sqr;
    logic  mul;
    logic  seed;
    logic  step;
    logic  load;
    logic  last;
    kind_e kind;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic has_res;
    logic last_col;
    logic last_row;
    logic root_done;
    logic out_free;
  } sts_t;

endpackage

>>> design/sobel_edge_magnitude_top.sv
// Flow: a pixel that gives no result passes intake, read and shift; each result beat adds
// gradient, square, scale multiply, seed, 21 bit-serial root steps plus a done check, load.
// Throughput: one pixel at a time; the root unit sets the rate, up to four beats per pixel.
// A finished beat waits in the output register while the next pixel is taken.
// Reset: asynchronous active low; counters, window, config and FSM return to defaults,
// line buffer contents are undefined until written. Config port is always ready.
module sobel_edge_magnitude_top #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  edge_res_o,
  output logic [9:0]  out_col_o,
  output logic [11:0] out_row_o,
  output logic        run_last_o,
  output logic        frame_done_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i
);
  import sem_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  sem_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  sem_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .edge_res_o  (edge_res_o),
    .out_col_o   (out_col_o),
    .out_row_o   (out_row_o),
    .run_last_o  (run_last_o),
    .frame_done_o(frame_done_o)
  );

  // The frame's final beat always closes its pixel's run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o |-> run_last_o)
    else $error("frame_done without run_last");

  // An accepted pixel keeps the block busy on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("pixel intake not serialized");

  // A beat is only loaded into a free output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> sts.out_free)
    else $error("output beat overwritten");
endmodule

>>> design/sem_ram.sv
// Generic single write port RAM with registered read.
module sem_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> design/sem_ctrl.sv
// Controller FSM: sequences pixel intake, line buffer access and result beats.
module sem_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sem_pkg::sts_t sts_i,
  output sem_pkg::cmd_t cmd_o
);
  import sem_pkg::*;

  state_e state_q, state_d;
  kind_e  kind_q, kind_d;
  kind_e  next_kind;
  logic   has_next;

  // Which result follows the current one
  always_comb begin
    has_next  = 1'b0;
    next_kind = KIND_DIAG;
    case (kind_q)
      KIND_DIAG: begin
        if (sts_i.last_col) begin
          has_next  = 1'b1;
          next_kind = KIND_RIGHT;
        end else if (sts_i.last_row) begin
          has_next  = 1'b1;
          next_kind = KIND_BOTTOM;
        end
      end
      KIND_RIGHT: begin
        has_next  = sts_i.last_row;
        next_kind = KIND_BOTTOM;
      end
      KIND_BOTTOM: begin
        has_next  = sts_i.last_col;
        next_kind = KIND_CORNER;
      end
      default: begin
        has_next  = 1'b0;
        next_kind = KIND_DIAG;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q  <= KIND_DIAG;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    cmd_o      = '0;
    cmd_o.kind = kind_q;
    cmd_o.last = !has_next;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.gray = 1'b1;
        state_d    = ST_SHIFT;
      end
      ST_SHIFT: begin
        cmd_o.shift = 1'b1;
        kind_d      = KIND_DIAG;
        state_d     = sts_i.has_res ? ST_GRAD : ST_IDLE;
      end
      ST_GRAD: begin
        cmd_o.grad = 1'b1;
        state_d    = ST_SQR;
      end
      ST_SQR: begin
        cmd_o.sqr = 1'b1;
        state_d   = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_SEED;
      end
      ST_SEED: begin
        cmd_o.seed = 1'b1;
        state_d    = ST_ROOT;
      end
      ST_ROOT: begin
        if (sts_i.root_done) begin
          state_d = ST_LOAD;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      ST_LOAD: begin
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          if (has_next) begin
            kind_d  = next_kind;
            state_d = ST_GRAD;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule

>>> design/sem_datapath.sv
// Datapath: config registers, counters, line buffers, window, gradient and root unit.
module sem_datapath #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sem_pkg::cmd_t cmd_i,
  output sem_pkg::sts_t sts_o,
  input  logic [7:0]    red_i,
  input  logic [7:0]    green_i,
  input  logic [7:0]    blue_i,
  input  logic          cfg_valid_i,
  input  logic [1:0]    cfg_index_i,
  input  logic [11:0]   cfg_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    edge_res_o,
  output logic [9:0]    out_col_o,
  output logic [11:0]   out_row_o,
  output logic          run_last_o,
  output logic          frame_done_o
);
  import sem_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned EW0 = CW + 1;
  localparam int unsigned EW  = (EW0 > 11) ? EW0 : 11;
  localparam int unsigned OW  = (CW > 10) ? CW : 10;

  // Config registers
  logic [10:0] fw_q;
  logic [11:0] fh_q, sens_q;
  logic        cfg_hit;

  // Position counters and item position
  logic [CW-1:0] col_cnt_q, item_col_q;
  logic [11:0]   row_cnt_q, item_row_q;
  logic [EW-1:0] w_eff, fw_ext;
  logic [11:0]   h_eff;

  // Pixel, window and buffer
  logic [7:0]       r_q, g_q, b_q, gray_q;
  logic [23:0]      gray_sum;
  logic [8:0][7:0]  win_q;
  logic [15:0]      ram_rdata;

  // Arithmetic pipeline
  logic [7:0]        ax_q, ay_q;
  logic [16:0]       mag_q;
  logic [23:0]       ss_q;
  logic [40:0]       prod_q;
  logic [RAD_W-1:0]  v_q, res_q, bit_q;
  logic [RAD_W:0]    trial;

  // Output register
  logic        ov_q;
  logic [7:0]  edge_q;
  logic [9:0]  ocol_q;
  logic [11:0] orow_q;
  logic        olast_q, odone_q;

  logic last_col, last_row;

  // Effective frame size
  always_comb begin
    fw_ext = EW'(fw_q);
    if (fw_ext < EW'(2)) begin
      w_eff = EW'(2);
    end else if (fw_ext > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = fw_ext;
    end
    h_eff = (fh_q < 12'd2) ? 12'd2 : fh_q;
  end

  assign cfg_hit  = cfg_valid_i && (cfg_index_i == CFG_WIDTH || cfg_index_i == CFG_HEIGHT
                                    || cfg_index_i == CFG_SENS);
  assign last_col = (EW'(item_col_q) == w_eff - EW'(1));
  assign last_row = (item_row_q == h_eff - 12'd1);

  // Config registers and raster counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q      <= 11'd500;
      fh_q      <= 12'd500;
      sens_q    <= 12'd256;
      col_cnt_q <= '0;
      row_cnt_q <= '0;
    end else if (cfg_hit) begin
      case (cfg_index_i)
        CFG_WIDTH:  fw_q   <= cfg_data_i[10:0];
        CFG_HEIGHT: fh_q   <= cfg_data_i;
        default:    sens_q <= cfg_data_i;
      endcase
      col_cnt_q <= '0;
      row_cnt_q <= '0;
    end else if (cmd_i.accept) begin
      if (EW'(col_cnt_q) + EW'(1) >= w_eff) begin
        col_cnt_q <= '0;
        if (13'(row_cnt_q) + 13'd1 >= 13'(h_eff)) begin
          row_cnt_q <= '0;
        end else begin
          row_cnt_q <= row_cnt_q + 12'd1;
        end
      end else begin
        col_cnt_q <= col_cnt_q + CW'(1);
      end
    end
  end

  // Item capture and gray conversion
  assign gray_sum = 24'(r_q) * 24'(COEF_R) + 24'(g_q) * 24'(COEF_G) + 24'(b_q) * 24'(COEF_B);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      r_q        <= red_i;
      g_q        <= green_i;
      b_q        <= blue_i;
      item_col_q <= col_cnt_q;
      item_row_q <= row_cnt_q;
    end
    if (cmd_i.gray) begin
      gray_q <= gray_sum[23:16];
    end
  end

  // Line buffers: low byte previous row, high byte the row before
  sem_ram #(.Width(16), .Depth(MAX_WIDTH)) u_lines (
    .clk_i  (clk_i),
    .we_i   (cmd_i.shift),
    .waddr_i(item_col_q),
    .wdata_i({ram_rdata[7:0], gray_q}),
    .raddr_i(item_col_q),
    .rdata_o(ram_rdata)
  );

  // 3x3 window, rows old to new, columns old to new
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (cmd_i.shift) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i*3]   <= win_q[i*3+1];
        win_q[i*3+1] <= win_q[i*3+2];
      end
      win_q[2] <= ram_rdata[15:8];
      win_q[5] <= ram_rdata[7:0];
      win_q[8] <= gray_q;
    end
  end

  function automatic logic [11:0] px(input logic [8:0][7:0] w, input logic [1:0] rr,
                                     input logic [1:0] cc);
    logic [3:0] idx;
    idx = 4'(rr) * 4'd3 + 4'(cc);
    return 12'(w[idx]);
  endfunction

  function automatic logic [7:0] clamp_abs(input logic [11:0] v);
    logic [11:0] a;
    a = v[11] ? (12'd0 - v) : v;
    return (a > 12'd255) ? 8'd255 : a[7:0];
  endfunction

  // Gradient stage: row and column selection per result kind
  logic [1:0]  tr, mr, br, lc, mc, rc, top_a, left_a;
  logic [11:0] gx, gy;

  always_comb begin
    top_a  = (item_row_q == 12'd1) ? 2'd2 : 2'd0;
    left_a = (item_col_q == CW'(1)) ? 2'd2 : 2'd0;
    if (cmd_i.kind == KIND_DIAG || cmd_i.kind == KIND_RIGHT) begin
      tr = top_a; mr = 2'd1; br = 2'd2;
    end else begin
      tr = 2'd1;  mr = 2'd2; br = 2'd1;
    end
    if (cmd_i.kind == KIND_DIAG || cmd_i.kind == KIND_BOTTOM) begin
      lc = left_a; mc = 2'd1; rc = 2'd2;
    end else begin
      lc = 2'd1;   mc = 2'd2; rc = 2'd1;
    end
    gx = (px(win_q, tr, rc) + (px(win_q, mr, rc) << 1) + px(win_q, br, rc))
       - (px(win_q, tr, lc) + (px(win_q, mr, lc) << 1) + px(win_q, br, lc));
    gy = (px(win_q, br, lc) + (px(win_q, br, mc) << 1) + px(win_q, br, rc))
       - (px(win_q, tr, lc) + (px(win_q, tr, mc) << 1) + px(win_q, tr, rc));
  end

  // Magnitude pipeline and bit-serial root
  assign trial = {1'b0, res_q} + {1'b0, bit_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.grad) begin
      ax_q <= clamp_abs(gx);
      ay_q <= clamp_abs(gy);
      ss_q <= 24'(sens_q) * 24'(sens_q);
    end
    if (cmd_i.sqr) begin
      mag_q <= 17'(16'(ax_q) * 16'(ax_q)) + 17'(16'(ay_q) * 16'(ay_q));
    end
    if (cmd_i.mul) begin
      prod_q <= 41'(ss_q) * 41'(mag_q);
    end
    if (cmd_i.seed) begin
      v_q   <= RAD_W'(prod_q);
      res_q <= '0;
      bit_q <= RAD_W'(1) << (RAD_W - 2);
    end else if (cmd_i.step) begin
      if ({1'b0, v_q} >= trial) begin
        v_q   <= v_q - trial[RAD_W-1:0];
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  // Output register
  logic [CW-1:0] res_col;
  logic [11:0]   res_row;
  logic [OW-1:0] res_col_w;

  always_comb begin
    res_col   = (cmd_i.kind == KIND_DIAG || cmd_i.kind == KIND_BOTTOM)
              ? item_col_q - CW'(1) : item_col_q;
    res_row   = (cmd_i.kind == KIND_DIAG || cmd_i.kind == KIND_RIGHT)
              ? item_row_q - 12'd1 : item_row_q;
    res_col_w = OW'(res_col);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.load) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      edge_q  <= (res_q[RAD_W-1:16] != '0) ? 8'd255 : res_q[15:8];
      ocol_q  <= res_col_w[9:0];
      orow_q  <= res_row;
      olast_q <= cmd_i.last;
      odone_q <= (cmd_i.kind == KIND_CORNER);
    end
  end

  assign out_valid_o  = ov_q;
  assign edge_res_o   = edge_q;
  assign out_col_o    = ocol_q;
  assign out_row_o    = orow_q;
  assign run_last_o   = olast_q;
  assign frame_done_o = odone_q;

  // Status to controller
  always_comb begin
    sts_o           = '0;
    sts_o.has_res   = (item_row_q != 12'd0) && (item_col_q != '0);
    sts_o.last_col  = last_col;
    sts_o.last_row  = last_row;
    sts_o.root_done = (bit_q == '0);
    sts_o.out_free  = !ov_q || out_ready_i;
  end
endmodule
